>>> src/pf_pkg.sv
// Shared types and constants for the prime factorizer.
// Used by prime_factorizer_core and the testbench; no dependencies.
package pf_pkg;

  // Smallest trial divisor.
  localparam int unsigned FIRST_DIVISOR = 2;

  // Upper bound on the number of results one input can produce.
  localparam int unsigned MAX_RESULTS = 31;
  localparam int unsigned EMIT_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_READ,
    ST_EMIT_LOAD
  } pf_state_e;

endpackage

>>> src/pf_stack.sv
// Factor stack memory: one write port, one registered read port.
// No package dependencies; instantiated by prime_factorizer_core.
module pf_stack #(
  parameter int unsigned DATA_W = 31,
  parameter int unsigned DEPTH  = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pf_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies; instantiated by prime_factorizer_core.
module pf_divider #(
  parameter int unsigned WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           ge;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> src/prime_factorizer_core.sv
// Top level of the trial-division prime factorizer.
// Depends on pf_pkg, pf_divider and pf_stack.

// Factorizes one unsigned value per transaction by trial division and returns
// its prime factors largest first, repeats included, with last_o on the final
// one; 0 and 1 give no results. Every trial runs one divide on the shared
// bit-serial divider, and every factor is read back from the stack through
// the EMIT_READ and EMIT_LOAD states. Trials is roughly the number of factors
// plus the larger of the second largest prime factor and the square root of
// the largest one. The worst case at 31 bits is about 46,000 trials.
// in_stall_o stays high from acceptance of a value of two or more until the
// last factor has been placed in the output register. At most STACK_DEPTH
// factors are kept (the smallest ones) and at most 31 are returned.
module prime_factorizer_core #(
  parameter int unsigned VALUE_BITS  = 31,
  parameter int unsigned STACK_DEPTH = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] factor_o,
  output logic                  last_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned EW    = pf_pkg::EMIT_W;

  pf_pkg::pf_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [EW-1:0]         emitted_q, emitted_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] factor_q, factor_d;
  logic                  last_q, last_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;
  logic                  trial_ok;
  logic                  stack_room;
  logic [CNT_W-1:0]      top;
  logic                  final_emit;

  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  logic [VALUE_BITS-1:0] st_wdata;
  logic                  st_re;
  logic [VALUE_BITS-1:0] st_rdata;

  assign in_stall_o = (state_q != pf_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign trial_ok   = (d_q <= div_quo);
  assign stack_room = (count_q < CNT_W'(STACK_DEPTH));
  assign top        = count_q - CNT_W'(1);
  assign final_emit = (count_q == CNT_W'(1)) ||
                      (emitted_q == EW'(pf_pkg::MAX_RESULTS - 1));

  pf_divider #(
    .WIDTH(VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  pf_stack #(
    .DATA_W(VALUE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(top[IDX_W-1:0]),
    .rdata_o(st_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pf_pkg::ST_IDLE: begin
        if (in_accept && (value_i >= VALUE_BITS'(pf_pkg::FIRST_DIVISOR))) begin
          state_d = pf_pkg::ST_DIV_START;
        end
      end
      pf_pkg::ST_DIV_START: begin
        state_d = pf_pkg::ST_DIV_WAIT;
      end
      pf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = trial_ok ? pf_pkg::ST_DIV_START : pf_pkg::ST_EMIT_READ;
        end
      end
      pf_pkg::ST_EMIT_READ: begin
        state_d = (count_q == '0) ? pf_pkg::ST_IDLE : pf_pkg::ST_EMIT_LOAD;
      end
      pf_pkg::ST_EMIT_LOAD: begin
        if (out_free) begin
          state_d = final_emit ? pf_pkg::ST_IDLE : pf_pkg::ST_EMIT_READ;
        end
      end
      default: state_d = pf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    n_d         = n_q;
    d_d         = d_q;
    count_d     = count_q;
    emitted_d   = emitted_q;
    out_valid_d = out_valid_q && out_stall_i;
    factor_d    = factor_q;
    last_d      = last_q;
    div_start   = 1'b0;
    st_we       = 1'b0;
    st_waddr    = count_q[IDX_W-1:0];
    st_wdata    = d_q;
    st_re       = 1'b0;
    unique case (state_q)
      pf_pkg::ST_IDLE: begin
        if (in_accept) begin
          n_d       = value_i;
          d_d       = VALUE_BITS'(pf_pkg::FIRST_DIVISOR);
          count_d   = '0;
          emitted_d = '0;
        end
      end
      pf_pkg::ST_DIV_START: begin
        div_start = 1'b1;
      end
      pf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          if (trial_ok) begin
            if (div_rem == '0) begin
              // Hit: keep the divisor and try it again on the quotient.
              n_d   = div_quo;
              st_we = stack_room;
              if (stack_room) begin
                count_d = count_q + CNT_W'(1);
              end
            end else begin
              d_d = d_q + VALUE_BITS'(1);
            end
          end else if (n_q > VALUE_BITS'(1)) begin
            // Divisor passed the square root, so the remainder is prime.
            st_we    = stack_room;
            st_wdata = n_q;
            if (stack_room) begin
              count_d = count_q + CNT_W'(1);
            end
          end
        end
      end
      pf_pkg::ST_EMIT_READ: begin
        st_re = (count_q != '0);
      end
      pf_pkg::ST_EMIT_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          factor_d    = st_rdata;
          last_d      = final_emit;
          count_d     = final_emit ? '0 : top;
          emitted_d   = emitted_q + EW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pf_pkg::ST_IDLE;
      count_q     <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;

endmodule

>>> src/pf_checker.sv
// Port-level assertions for prime_factorizer_core, bound to the top level.
// Depends only on the top level's ports.
module pf_checker #(
  parameter int unsigned VALUE_BITS = 31
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [VALUE_BITS-1:0] factor_o,
  input logic                  last_o
);

  // Every returned factor is at least two.
  a_factor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (factor_o >= VALUE_BITS'(2)))
    else $error("factor below two");

  // A transaction with zero or one produces nothing and the block stays ready.
  a_trivial_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (value_i < VALUE_BITS'(2))) |=> !in_stall_o)
    else $error("trivial value left the block busy");

  // A value of two or more starts a factorization and the input is held off.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (value_i >= VALUE_BITS'(2))) |=> in_stall_o)
    else $error("input not stalled during factorization");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(factor_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind prime_factorizer_core pf_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_pf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .factor_o   (factor_o),
  .last_o     (last_o)
);

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for prime_factorizer_core: directed and random values,
// factors typed or predicted in the bench and compared in order. Depends on pf_pkg.
module tb;

  localparam int unsigned VALUE_BITS   = 31;
  localparam int unsigned STACK_DEPTH  = 31;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT   = 200000;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct {
    value_t factor;
    logic   last;
  } factor_t;

  typedef enum bit {
    CHECK_TYPED,
    CHECK_PREDICT
  } check_e;

  // Typed rows expect count copies of factor; predicted rows ignore both.
  typedef struct {
    value_t      value;
    check_e      check;
    value_t      factor;
    int unsigned count;
  } row_t;

  row_t directed_rows [18] = '{
    '{31'd0,          CHECK_TYPED,   31'd0,       0},
    '{31'd1,          CHECK_TYPED,   31'd0,       0},
    '{31'd2,          CHECK_TYPED,   31'd2,       1},
    '{31'd3,          CHECK_TYPED,   31'd3,       1},
    '{31'd4,          CHECK_TYPED,   31'd2,       2},
    '{31'd97,         CHECK_TYPED,   31'd97,      1},
    '{31'd65521,      CHECK_TYPED,   31'd65521,   1},
    '{31'd1000003,    CHECK_TYPED,   31'd1000003, 1},
    '{31'd1073741824, CHECK_TYPED,   31'd2,       30},
    '{31'd1162261467, CHECK_TYPED,   31'd3,       19},
    '{31'd6,          CHECK_PREDICT, 31'd0,       0},
    '{31'd49,         CHECK_PREDICT, 31'd0,       0},
    '{31'd360,        CHECK_PREDICT, 31'd0,       0},
    '{31'd999999,     CHECK_PREDICT, 31'd0,       0},
    '{31'd2147483646, CHECK_PREDICT, 31'd0,       0},
    '{31'd1073741823, CHECK_PREDICT, 31'd0,       0},
    '{31'd715827882,  CHECK_PREDICT, 31'd0,       0},
    '{31'd1431655765, CHECK_PREDICT, 31'd0,       0}
  };

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  value_t value     = '0;
  logic   out_valid;
  logic   out_stall = 1'b1;
  value_t factor;
  logic   last;

  factor_t     expected_factors [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;

  prime_factorizer_core #(
    .VALUE_BITS (VALUE_BITS),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .value_i    (value),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .factor_o   (factor),
    .last_o     (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Trial division with a bounded stack; factors come out from the top, and
  // no more than the result limit of them.
  function automatic void predict_factors(input value_t v);
    longint unsigned rem = v;
    longint unsigned d   = pf_pkg::FIRST_DIVISOR;
    value_t          stack [$];
    int unsigned     n_out;
    if (rem < 2) return;
    while (d * d <= rem) begin
      if (rem % d == 0) begin
        if (stack.size() < STACK_DEPTH) stack.push_back(value_t'(d));
        rem = rem / d;
      end else begin
        d++;
      end
    end
    if (rem > 1 && stack.size() < STACK_DEPTH) stack.push_back(value_t'(rem));
    n_out = (stack.size() < pf_pkg::MAX_RESULTS) ? stack.size() : pf_pkg::MAX_RESULTS;
    for (int unsigned k = 0; k < n_out; k++) begin
      expected_factors.push_back('{stack[stack.size() - 1 - k], k == n_out - 1});
    end
  endfunction

  // Mostly products of small numbers so that trials stay short; some carry one
  // mid-size factor, a few are raw 20-bit values or values below four.
  function automatic value_t pick_value();
    longint unsigned acc = 1;
    longint unsigned f;
    int unsigned     sel    = $urandom_range(0, 99);
    int unsigned     target = $urandom_range(1, VALUE_BITS);
    if (sel < 8) return value_t'($urandom_range(0, 3));
    if (sel < 18) return value_t'($urandom_range(0, (1 << 20) - 1));
    if (sel < 38) acc = $urandom_range(2, 65535);
    forever begin
      f = $urandom_range(2, 64);
      if (acc * f >= (64'd1 << target)) break;
      acc = acc * f;
    end
    return value_t'(acc);
  endfunction

  task automatic offer(input row_t row);
    in_valid <= 1'b1;
    value    <= row.value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.check == CHECK_TYPED) begin
      for (int i = row.count; i > 0; i--) begin
        expected_factors.push_back('{row.factor, i == 1});
      end
    end else begin
      predict_factors(row.value);
    end
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    value    <= value_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    @(posedge rst_n);
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i]);
      idle_gap(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
    end

    // Back-to-back transactions while the receiver holds off, so the
    // output register fills and the input side stalls.
    hold_req = 1'b1;
    sent = 0;
    repeat (8) begin
      offer('{pick_value(), CHECK_PREDICT, '0, 0});
      sent++;
    end

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        offer('{pick_value(), CHECK_PREDICT, '0, 0});
        sent++;
        burst--;
      end
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
    end
    idle_gap(1);

    while (expected_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("prime_factorizer_core: match");
    end else begin
      $display("prime_factorizer_core: mismatch");
    end
    $finish;
  end

  // Receiver stalls in segments of random mode and length; mode 0 never stalls.
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned phase;
    bit          hold_done;
    logic        stall;
    seg_left  = 0;
    mode      = 0;
    phase     = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        phase++;
        case (mode)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 3) == 0);
          2: stall = 1'($urandom_range(0, 1));
          default: stall = (phase % 7) < 3;
        endcase
        out_stall <= stall;
      end
    end
  end

  always @(posedge clk) begin
    factor_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_factors.size() == 0) begin
        $display("%0t: unexpected factor %0d last %0b", $time, factor, last);
        mismatches++;
      end else begin
        exp_f = expected_factors.pop_front();
        if (factor !== exp_f.factor) begin
          $display("%0t: factor expected %0d actual %0d", $time, exp_f.factor, factor);
          mismatches++;
        end
        if (last !== exp_f.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_f.last, last);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if no transaction completes on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("prime_factorizer_core: mismatch");
        $finish;
      end
    end
  end

endmodule
